[sv/ber_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ber_pkg;

    // store geometry
    localparam int BANDS      = 32;
    localparam int FRAMES     = 32;
    localparam int LEVEL_BITS = 16;

    // field widths of the channels
    localparam int BAND_FW  = 5;
    localparam int FRAME_FW = 5;
    localparam int LEVEL_FW = 16;
    localparam int RANK_FW  = 5;
    localparam int TOTAL_W  = 21;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // at most this many bands take part in one ranking
    localparam int MAX_RANKED = 32;
    localparam int BAND_CAP   = (BANDS < MAX_RANKED) ? BANDS : MAX_RANKED;

    localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int HIST_AW = BAND_W + FRAME_W;
    localparam int LVL_W   = (LEVEL_BITS < LEVEL_FW) ? LEVEL_BITS : LEVEL_FW;
    localparam int RB_W    = $clog2(BAND_CAP);
    localparam int NB_W    = $clog2(BAND_CAP + 1);
    localparam int NF_W    = $clog2(FRAMES + 1);

    // configuration port
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BANDS_IN_USE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'd1;

    localparam logic [CFG_W-1:0] CFG_BANDS_RST  = 6'd32;
    localparam logic [CFG_W-1:0] CFG_FRAMES_RST = 6'd32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SUM,
        ST_SCAN,
        ST_EMIT
    } t_state;

    function automatic logic [NB_W-1:0] f_clamp_bands(input logic [CFG_W-1:0] v);
        logic [NB_W-1:0] res;
        if (v == '0) begin
            res = NB_W'(1);
        end else if (int'(v) > BAND_CAP) begin
            res = NB_W'(BAND_CAP);
        end else begin
            res = NB_W'(v);
        end
        return res;
    endfunction

    function automatic logic [NF_W-1:0] f_clamp_frames(input logic [CFG_W-1:0] v);
        logic [NF_W-1:0] res;
        if (v == '0) begin
            res = NF_W'(1);
        end else if (int'(v) > FRAMES) begin
            res = NF_W'(FRAMES);
        end else begin
            res = NF_W'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/ber_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ber_in_if import ber_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BAND_FW-1:0]  band;
    logic [FRAME_FW-1:0] frame;
    logic [LEVEL_FW-1:0] level;
    logic                last;

    modport source (output valid, output band, output frame, output level, output last,
                     input ready);
    modport sink   (input valid, input band, input frame, input level, input last,
                     output ready);
endinterface

interface ber_out_if import ber_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RANK_FW-1:0] rank;
    logic [BAND_FW-1:0] band_index;
    logic [TOTAL_W-1:0] band_total;
    logic               final_res;

    modport source (output valid, output rank, output band_index, output band_total,
                     output final_res, input ready);
    modport sink   (input valid, input rank, input band_index, input band_total,
                     input final_res, output ready);
endinterface

`default_nettype wire

[sv/band_energy_ranker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                   Transfer
// i_in     in   band, frame, level, last                  valid & ready
// o_out    out  rank, band_index, band_total, final_res   valid & ready
// i_cfg    in   we, idx, wdata                            we (no wait)
//
// Loading: one sample per cycle into the history memory while idle.
// A sample flagged last starts the ranking; input ready stays low until the
// final result transfers. Summing walks the history memory one read per cycle.
// Each rank then scans the sum memory, and each result holds through any stall
// on o_out. No clearing pass: the memories need no reset contents.

module band_energy_ranker_unit import ber_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ber_in_if.sink               i_in,
    ber_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    t_state r_state;
    t_state n_state;

    // configuration
    logic [CFG_W-1:0] r_cfg_bands;
    logic [CFG_W-1:0] r_cfg_frames;

    // ranking geometry, latched when the ranking starts
    logic [NB_W-1:0] r_nb;
    logic [NF_W-1:0] r_nf;
    logic [NB_W-1:0] nb_last;
    logic [NF_W-1:0] nf_last;

    logic in_xfer;
    logic out_xfer;
    logic start;
    logic in_range;

    // summing: read issue side
    logic            r_iss_on;
    logic [NB_W-1:0] r_ib;
    logic [NF_W-1:0] r_if;
    // summing: data side, registered behind the issue side
    logic            r_p_vld;
    logic            r_p_first;
    logic            r_p_last;
    logic            r_p_end;
    logic [RB_W-1:0] r_p_band;
    logic [TOTAL_W-1:0] r_acc;
    logic [TOTAL_W-1:0] acc_base;
    logic [TOTAL_W:0]   acc_wide;
    logic [TOTAL_W-1:0] acc_sat;
    logic               sum_done;

    // scanning
    logic            r_sk_on;
    logic [NB_W-1:0] r_sk;
    logic            r_q_vld;
    logic            r_q_end;
    logic [RB_W-1:0] r_q_idx;
    logic               r_have;
    logic [TOTAL_W-1:0] r_best_sum;
    logic [RB_W-1:0]    r_best_idx;
    logic               take;
    logic               scan_done;
    logic [BAND_CAP-1:0] r_picked;
    logic [NB_W-1:0]     r_rank;
    logic                is_final;
    logic                rescan;

    // memory ports
    logic [HIST_AW-1:0] hist_waddr;
    logic [HIST_AW-1:0] hist_raddr;
    logic [LVL_W-1:0]   hist_rdata;
    logic [TOTAL_W-1:0] sums_rdata;

    assign in_xfer  = i_in.valid & i_in.ready;
    assign out_xfer = o_out.valid & o_out.ready;
    assign start    = in_xfer & i_in.last;
    assign in_range = (int'(i_in.band) < BANDS) && (int'(i_in.frame) < FRAMES);
    assign nb_last  = r_nb - NB_W'(1);
    assign nf_last  = r_nf - NF_W'(1);
    assign is_final = (r_rank == nb_last);
    assign rescan   = out_xfer & ~is_final;

    // ---------------------------------------------------------------
    // State machine
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (start) n_state = ST_SUM;
            end
            ST_SUM: begin
                if (sum_done) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_xfer) n_state = is_final ? ST_LOAD : ST_SCAN;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        case (r_state)
            ST_LOAD: i_in.ready  = 1'b1;
            ST_EMIT: o_out.valid = 1'b1;
            default: begin
                i_in.ready  = 1'b0;
                o_out.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // Configuration: unenforced by the block, the user must write it only while idle
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bands  <= CFG_BANDS_RST;
            r_cfg_frames <= CFG_FRAMES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BANDS_IN_USE:  r_cfg_bands  <= i_cfg_wdata;
                REG_FRAMES_IN_USE: r_cfg_frames <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // latch the saturated geometry for the whole ranking
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_nb <= f_clamp_bands(r_cfg_bands);
            r_nf <= f_clamp_frames(r_cfg_frames);
        end
    end

    // ---------------------------------------------------------------
    // History memory: samples land at {frame, band}, out-of-range dropped
    // ---------------------------------------------------------------
    assign hist_waddr = {FRAME_W'(i_in.frame), BAND_W'(i_in.band)};
    assign hist_raddr = {FRAME_W'(r_if), BAND_W'(r_ib)};

    ber_ram #(
        .DW (LVL_W),
        .AW (HIST_AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (in_xfer & in_range),
        .i_waddr (hist_waddr),
        .i_wdata (LVL_W'(i_in.level)),
        .i_re    (r_iss_on),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    // ---------------------------------------------------------------
    // Summing: walk frames inside bands, one read per cycle.
    // The last sample was written at the start edge, so the first read,
    // issued in the following cycle, already sees it.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_on <= 1'b0;
            r_p_vld  <= 1'b0;
        end else begin
            r_p_vld <= r_iss_on;
            if (start) begin
                r_iss_on <= 1'b1;
            end else if (r_iss_on && r_if == nf_last && r_ib == nb_last) begin
                r_iss_on <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_ib <= '0;
            r_if <= '0;
        end else if (r_iss_on) begin
            if (r_if == nf_last) begin
                r_if <= '0;
                r_ib <= r_ib + NB_W'(1);
            end else begin
                r_if <= r_if + NF_W'(1);
            end
        end
        // tag the read so the data side knows where it belongs
        r_p_first <= (r_if == '0);
        r_p_last  <= (r_if == nf_last);
        r_p_end   <= (r_if == nf_last) && (r_ib == nb_last);
        r_p_band  <= RB_W'(r_ib);
    end

    // saturating accumulate, restarted on each band's first frame
    assign acc_base = r_p_first ? '0 : r_acc;
    assign acc_wide = {1'b0, acc_base} + (TOTAL_W + 1)'(hist_rdata);
    assign acc_sat  = acc_wide[TOTAL_W] ? TOTAL_MAX : acc_wide[TOTAL_W-1:0];
    assign sum_done = r_p_vld & r_p_end;

    always_ff @(posedge i_clk) begin
        if (r_p_vld) begin
            r_acc <= acc_sat;
        end
    end

    ber_ram #(
        .DW (TOTAL_W),
        .AW (RB_W)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_p_vld & r_p_last),
        .i_waddr (r_p_band),
        .i_wdata (acc_sat),
        .i_re    (r_sk_on),
        .i_raddr (RB_W'(r_sk)),
        .o_rdata (sums_rdata)
    );

    // ---------------------------------------------------------------
    // Ranking: one scan of the sums per rank picks the largest band not
    // yet ranked. Strict compare keeps the lower band on equal sums.
    // ---------------------------------------------------------------
    assign take      = r_q_vld & ~r_picked[r_q_idx] & (~r_have | (sums_rdata > r_best_sum));
    assign scan_done = r_q_vld & r_q_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk_on <= 1'b0;
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= r_sk_on;
            if (sum_done || rescan) begin
                r_sk_on <= 1'b1;
            end else if (r_sk_on && r_sk == nb_last) begin
                r_sk_on <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_done || rescan) begin
            r_sk <= '0;
        end else if (r_sk_on) begin
            r_sk <= r_sk + NB_W'(1);
        end
        r_q_end <= (r_sk == nb_last);
        r_q_idx <= RB_W'(r_sk);
    end

    always_ff @(posedge i_clk) begin
        if (sum_done || rescan) begin
            r_have <= 1'b0;
        end else if (take) begin
            r_have     <= 1'b1;
            r_best_sum <= sums_rdata;
            r_best_idx <= r_q_idx;
        end
    end

    // clear the picked marks for each ranking, mark on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_picked <= '0;
            r_rank   <= '0;
        end else if (start) begin
            r_picked <= '0;
            r_rank   <= '0;
        end else if (out_xfer) begin
            r_picked[r_best_idx] <= 1'b1;
            r_rank               <= r_rank + NB_W'(1);
        end
    end

    // hold the winner on the output until it transfers
    assign o_out.rank       = RANK_FW'(r_rank);
    assign o_out.band_index = BAND_FW'(r_best_idx);
    assign o_out.band_total = r_best_sum;
    assign o_out.final_res  = is_final;

endmodule

`default_nettype wire

[sv/ber_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ber_ram #(
    parameter int DW = 16,
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/ber_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ber_checker import ber_pkg::*; (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                i_in_ready,
    input wire                i_in_last,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire [RANK_FW-1:0]  i_out_rank,
    input wire [BAND_FW-1:0]  i_out_band_index,
    input wire [TOTAL_W-1:0]  i_out_band_total,
    input wire                i_out_final_res
);

    // loading and result delivery never overlap
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a result is shown");

    // a last sample closes the input until the ranking is delivered
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input reopened right after a last sample");

    // the final result reopens loading
    a_final_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_final_res |=> i_in_ready && !i_out_valid)
        else $error("loading not resumed after the final result");

    // more results follow a non-final one
    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_final_res |=> !i_in_ready)
        else $error("ranking cut short");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_rank)
            && $stable(i_out_band_index) && $stable(i_out_band_total))
        else $error("stalled result changed");

endmodule

bind band_energy_ranker_unit ber_checker u_ber_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_last        (i_in.last),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_rank       (o_out.rank),
    .i_out_band_index (o_out.band_index),
    .i_out_band_total (o_out.band_total),
    .i_out_final_res  (o_out.final_res)
);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ber_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int LOAD_SETTLE  = 4;    // cycles for a load write still in flight
    localparam int END_SETTLE   = 40;
    localparam int MAX_SHOWN    = 10;
    localparam int RANDOM_ITEMS = 180;
    localparam int RANDOM_AREA  = 32;
    localparam int LONG_HOLD    = 300;

    localparam logic [LEVEL_FW-1:0] LEVEL_KEEP = LEVEL_FW'((64'd1 << LVL_W) - 1);

    typedef struct packed {
        logic [RANK_FW-1:0] rank;
        logic [BAND_FW-1:0] band_index;
        logic [TOTAL_W-1:0] band_total;
        logic               final_res;
    } ranked_band_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_wdata;

    ber_in_if  in_if ();
    ber_out_if out_if ();

    band_energy_ranker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Shadow of the block: level store, which entries hold a written sample,
    // and the two setting registers as last written.
    logic [LEVEL_FW-1:0] level_mem   [FRAMES][BANDS];
    bit                  level_known [FRAMES][BANDS];
    logic [CFG_W-1:0]    bands_reg;
    logic [CFG_W-1:0]    frames_reg;

    // Rankings still owed by the block, oldest first.
    ranked_band_t pending_ranks [$];

    int          error_count  = 0;
    int          result_count = 0;
    int          items_sent   = 0;
    int          hold_left    = 0;
    int unsigned cycle_count  = 0;
    bit          sender_burst = 1'b0;
    bit          sink_burst   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung block ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Long hold-off on the result side, counted down one cycle at a time.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Register values outside 1..cap saturate.
    function automatic int ranked_bands();
        if (bands_reg == '0) begin
            return 1;
        end
        return (int'(bands_reg) > BAND_CAP) ? BAND_CAP : int'(bands_reg);
    endfunction

    function automatic int summed_frames();
        if (frames_reg == '0) begin
            return 1;
        end
        return (int'(frames_reg) > FRAMES) ? FRAMES : int'(frames_reg);
    endfunction

    // Store the sample; on last, total every band in use and queue the bands
    // from the largest total down, the lower band first among equal totals.
    function automatic void store_and_rank(input logic [BAND_FW-1:0]  band,
                                           input logic [FRAME_FW-1:0] frame,
                                           input logic [LEVEL_FW-1:0] level,
                                           input logic                last);
        int           nb;
        int           nf;
        int           total;
        int           pick;
        int           totals [BANDS];
        bit           taken  [BANDS];
        ranked_band_t entry;

        if (int'(band) < BANDS && int'(frame) < FRAMES) begin
            level_mem[frame][band]   = level & LEVEL_KEEP;
            level_known[frame][band] = 1'b1;
        end
        if (!last) begin
            return;
        end

        nb = ranked_bands();
        nf = summed_frames();
        for (int b = 0; b < nb; b++) begin
            total = 0;
            for (int f = 0; f < nf; f++) begin
                total += int'(level_mem[f][b]);
                if (total > int'(TOTAL_MAX)) begin
                    total = int'(TOTAL_MAX);
                end
            end
            totals[b] = total;
            taken[b]  = 1'b0;
        end

        // strict compare keeps the lowest band on a tie
        for (int pos = 0; pos < nb; pos++) begin
            pick = -1;
            for (int b = 0; b < nb; b++) begin
                if (!taken[b] && (pick < 0 || totals[b] > totals[pick])) begin
                    pick = b;
                end
            end
            taken[pick]      = 1'b1;
            entry.rank       = RANK_FW'(pos);
            entry.band_index = BAND_FW'(pick);
            entry.band_total = TOTAL_W'(totals[pick]);
            entry.final_res  = (pos == nb - 1);
            pending_ranks.push_back(entry);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls per transfer, and the checker
    // ------------------------------------------------------------------

    initial begin : result_sink
        int stall;
        stall = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                stall = sink_burst ? 0 : $urandom_range(0, 14);
            end else if (stall > 0) begin
                stall--;
            end
            out_if.ready <= (stall == 0) && (hold_left == 0) && i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        ranked_band_t got;
        ranked_band_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.rank       = out_if.rank;
            got.band_index = out_if.band_index;
            got.band_total = out_if.band_total;
            got.final_res  = out_if.final_res;
            if (pending_ranks.size() == 0) begin
                error_count++;
                if (error_count <= MAX_SHOWN) begin
                    $display("result %0d: none expected, got rank %0d band %0d total %0d last %0b",
                             result_count, got.rank, got.band_index, got.band_total,
                             got.final_res);
                end
            end else begin
                want = pending_ranks.pop_front();
                if (got.rank !== want.rank || got.band_index !== want.band_index ||
                    got.band_total !== want.band_total || got.final_res !== want.final_res) begin
                    error_count++;
                    if (error_count <= MAX_SHOWN) begin
                        $display("result %0d: expected rank %0d band %0d total %0d last %0b",
                                 result_count, want.rank, want.band_index, want.band_total,
                                 want.final_res);
                        $display("result %0d:      got rank %0d band %0d total %0d last %0b",
                                 result_count, got.rank, got.band_index, got.band_total,
                                 got.final_res);
                    end
                end
            end
            result_count++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [LEVEL_FW-1:0] random_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return LEVEL_FW'($urandom_range(0, 3));   // small values force ties
            default: return LEVEL_FW'($urandom());
        endcase
    endfunction

    function automatic logic [BAND_FW-1:0] any_band();
        return BAND_FW'($urandom_range(0, (1 << BAND_FW) - 1));
    endfunction

    function automatic logic [FRAME_FW-1:0] any_frame();
        return FRAME_FW'($urandom_range(0, (1 << FRAME_FW) - 1));
    endfunction

    // Mostly small shapes; zero, all ones and the cap come up often.
    function automatic logic [CFG_W-1:0] random_setting();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'(32);
            3:       return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Offer one sample after a random gap; valid stays high on return so a
    // zero gap on the next call gives back-to-back transfers.
    task automatic send_sample(input logic [BAND_FW-1:0]  band,
                               input logic [FRAME_FW-1:0] frame,
                               input logic [LEVEL_FW-1:0] level,
                               input logic                last);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.band  <= band;
        in_if.frame <= frame;
        in_if.level <= level;
        in_if.last  <= last;
        do @(posedge i_clk); while (!in_if.ready);
        store_and_rank(band, frame, level, last);
        items_sent++;
    endtask

    // Drop valid, wait until every owed result has transferred, then let a
    // trailing load write land.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_ranks.size() != 0) @(posedge i_clk);
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] bands, input logic [CFG_W-1:0] frames);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_BANDS_IN_USE;
        i_cfg_wdata <= bands;
        @(posedge i_clk);
        bands_reg    = bands;
        i_cfg_idx   <= REG_FRAMES_IN_USE;
        i_cfg_wdata <= frames;
        @(posedge i_clk);
        frames_reg  = frames;
        i_cfg_we   <= 1'b0;
    endtask

    // Write every entry the next ranking will read that holds no sample yet.
    task automatic fill_region();
        for (int f = 0; f < summed_frames(); f++) begin
            for (int b = 0; b < ranked_bands(); b++) begin
                if (!level_known[f][b]) begin
                    send_sample(BAND_FW'(b), FRAME_FW'(f), random_level(), 1'b0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One band over one frame, first at full scale, then with zero settings and a zero level.
    task automatic test_single_entry();
        set_config(CFG_W'(1), CFG_W'(1));
        send_sample('0, '0, '1, 1'b1);
        set_config('0, '0);
        send_sample('0, '0, '0, 1'b1);
        drain_results();
    endtask

    // Three bands with equal totals must come out in band order.
    task automatic test_tie_order();
        set_config(CFG_W'(4), CFG_W'(2));
        send_sample(BAND_FW'(0), FRAME_FW'(0), LEVEL_FW'(5), 1'b0);
        send_sample(BAND_FW'(0), FRAME_FW'(1), LEVEL_FW'(5), 1'b0);
        send_sample(BAND_FW'(1), FRAME_FW'(0), LEVEL_FW'(10), 1'b0);
        send_sample(BAND_FW'(1), FRAME_FW'(1), '0, 1'b0);
        send_sample(BAND_FW'(2), FRAME_FW'(0), '0, 1'b0);
        send_sample(BAND_FW'(2), FRAME_FW'(1), LEVEL_FW'(10), 1'b0);
        send_sample(BAND_FW'(3), FRAME_FW'(0), '1, 1'b0);
        send_sample(BAND_FW'(3), FRAME_FW'(1), '1, 1'b1);
        drain_results();
    endtask

    // Plain loads give no result; the ranking sees the newest sample, and a
    // last flag outside the ranked area still starts it.
    task automatic test_quiet_loads();
        send_sample(BAND_FW'(31), FRAME_FW'(31), LEVEL_FW'(16'h1234), 1'b0);
        send_sample(BAND_FW'(17), FRAME_FW'(30), '1, 1'b0);
        send_sample(BAND_FW'(0), FRAME_FW'(0), LEVEL_FW'(16'hAAAA), 1'b0);
        send_sample(BAND_FW'(1), FRAME_FW'(1), LEVEL_FW'(16'h5555), 1'b0);
        send_sample(BAND_FW'(20), FRAME_FW'(9), LEVEL_FW'(42), 1'b1);
        drain_results();
    endtask

    // All bands over one frame, then one band over all frames.
    task automatic test_wide_shapes();
        set_config(CFG_W'(32), CFG_W'(1));
        fill_region();
        send_sample(BAND_FW'(31), '0, '1, 1'b1);
        set_config(CFG_W'(1), CFG_W'(32));
        fill_region();
        send_sample('0, FRAME_FW'(31), '0, 1'b1);
        drain_results();
    endtask

    // Oversized settings saturate to the full band count and to the full
    // frame count; one band at full scale in every frame gives the largest
    // possible total.
    task automatic test_full_store();
        set_config(CFG_W'(63), CFG_W'(1));
        fill_region();
        send_sample(BAND_FW'(5), '0, '1, 1'b1);
        set_config(CFG_W'(1), CFG_W'(40));
        sender_burst = 1'b1;
        for (int f = 0; f < FRAMES - 1; f++) begin
            send_sample('0, FRAME_FW'(f), '1, 1'b0);
        end
        sender_burst = 1'b0;
        send_sample('0, FRAME_FW'(FRAMES - 1), '1, 1'b1);
        drain_results();
    endtask

    // Hold the result side off while samples keep coming so the block backs
    // up into its input, then pause the sender until everything is out.
    task automatic test_backpressure();
        set_config(CFG_W'(8), CFG_W'(3));
        fill_region();
        hold_left    <= LONG_HOLD;
        sender_burst  = 1'b1;
        send_sample(BAND_FW'(2), FRAME_FW'(1), random_level(), 1'b1);
        repeat (5) send_sample(any_band(), any_frame(), random_level(), 1'b0);
        send_sample(any_band(), any_frame(), random_level(), 1'b1);
        repeat (5) send_sample(any_band(), any_frame(), random_level(), 1'b0);
        sender_burst = 1'b0;
        drain_results();
    endtask

    // Rounds of random loads ending in a ranking, with some rounds of loads
    // only; settings change between rounds.
    task automatic test_random_traffic();
        int               first_item;
        int               nb;
        int               nf;
        logic [CFG_W-1:0] bands_pick;
        logic [CFG_W-1:0] frames_pick;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            sender_burst = ($urandom_range(0, 3) == 0);
            sink_burst   = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                bands_pick  = random_setting();
                frames_pick = random_setting();
                // keep the ranked area small so filling it stays cheap
                if (int'(f_clamp_bands(bands_pick)) * int'(f_clamp_frames(frames_pick))
                        > RANDOM_AREA) begin
                    frames_pick = CFG_W'(1);
                end
                set_config(bands_pick, frames_pick);
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 5))
                    send_sample(any_band(), any_frame(), random_level(), 1'b0);
            end else begin
                repeat ($urandom_range(0, 6))
                    send_sample(any_band(), any_frame(), random_level(), 1'b0);
                fill_region();
                nb = ranked_bands();
                nf = summed_frames();
                if ($urandom_range(0, 1) == 0) begin
                    send_sample(BAND_FW'($urandom_range(0, nb - 1)),
                                FRAME_FW'($urandom_range(0, nf - 1)), random_level(), 1'b1);
                end else begin
                    send_sample(any_band(), any_frame(), random_level(), 1'b1);
                end
            end
        end
        sender_burst = 1'b0;
        sink_burst   = 1'b0;
        drain_results();
    endtask

    initial begin : run_tests
        in_if.valid <= 1'b0;
        in_if.band  <= '0;
        in_if.frame <= '0;
        in_if.level <= '0;
        in_if.last  <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_BANDS_IN_USE;
        i_cfg_wdata <= '0;
        i_rst_n     <= 1'b0;

        // shadow state after reset: nothing written, settings at full size
        bands_reg  = CFG_BANDS_RST;
        frames_reg = CFG_FRAMES_RST;
        for (int f = 0; f < FRAMES; f++) begin
            for (int b = 0; b < BANDS; b++) begin
                level_known[f][b] = 1'b0;
                level_mem[f][b]   = '0;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_entry();
        test_tie_order();
        test_quiet_loads();
        test_wide_shapes();
        test_full_store();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (END_SETTLE) @(posedge i_clk);
        if (error_count == 0 && pending_ranks.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

[files.f]
sv/ber_pkg.sv
sv/ber_if.sv
sv/ber_ram.sv
sv/band_energy_ranker_unit.sv
sv/ber_checker.sv
tb/tb_top.sv
